@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file secs_checker.sv.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define SECS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define SECS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/secs_pkg.sv @@
// Shared types and constants for the SPI EEPROM command sequencer.
// No dependencies; every other file but assert_macros.svh imports this package.
`default_nettype none

package secs_pkg;

  // Field widths
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned IN_ADDR_W  = 19;
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned LOG_W      = 5;
  localparam int unsigned NB_W       = 2;

  // Internal address space (three header bytes)
  localparam int unsigned ADDR_BITS  = 24;
  localparam int unsigned A8_BIT     = 8;

  // Configuration reset values
  localparam logic [LOG_W-1:0] CAP_LOG2_RST  = 5'd13;
  localparam logic [LOG_W-1:0] PAGE_LOG2_RST = 5'd5;
  localparam logic [NB_W-1:0]  ADDR_BYTES_RST = 2'd2;

  // Command queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // EEPROM opcodes
  localparam logic [BYTE_W-1:0] OP_WREN     = 8'h06;
  localparam logic [BYTE_W-1:0] OP_RDSR     = 8'h05;
  localparam logic [BYTE_W-1:0] OP_WRSR     = 8'h01;
  localparam logic [BYTE_W-1:0] OP_READ     = 8'h03;
  localparam logic [BYTE_W-1:0] OP_WRITE    = 8'h02;
  localparam logic [BYTE_W-1:0] OP_READ_A8  = 8'h0B;
  localparam logic [BYTE_W-1:0] OP_WRITE_A8 = 8'h0A;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEGIN_WRITE  = 3'd0,
    MODE_WRITE_DATA   = 3'd1,
    MODE_BEGIN_READ   = 3'd2,
    MODE_WRITE_STATUS = 3'd3,
    MODE_READ_STATUS  = 3'd4
  } secs_mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND    = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_POLL    = 3'd2,
    KIND_RECEIVE = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_DONE    = 3'd5
  } secs_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY_LOG2      = 2'd0,
    CFG_PAGE_LOG2          = 2'd1,
    CFG_ADDRESS_BYTES      = 2'd2,
    CFG_HIGH_BIT_IN_OPCODE = 2'd3
  } secs_cfg_e;

  // Result slots in emission order; a command enables a subset of them
  typedef enum logic [3:0] {
    SLOT_PRE_RELEASE  = 4'd0,
    SLOT_PRE_POLL     = 4'd1,
    SLOT_READY_POLL   = 4'd2,
    SLOT_WREN         = 4'd3,
    SLOT_WREN_RELEASE = 4'd4,
    SLOT_OPCODE       = 4'd5,
    SLOT_ADDR_HI      = 4'd6,
    SLOT_ADDR_MID     = 4'd7,
    SLOT_ADDR_LO      = 4'd8,
    SLOT_DATA         = 4'd9,
    SLOT_RECEIVE      = 4'd10,
    SLOT_END_RELEASE  = 4'd11,
    SLOT_END_POLL     = 4'd12,
    SLOT_DONE         = 4'd13,
    SLOT_ERROR        = 4'd14
  } secs_slot_e;

  localparam int unsigned SLOT_COUNT = 15;

  typedef logic [SLOT_COUNT-1:0] secs_mask_t;

  // One classified command, as queued between front and back
  typedef struct packed {
    secs_mask_t             mask;
    logic [BYTE_W-1:0]      opcode;
    logic [ADDR_BITS-1:0]   addr;
    logic [BYTE_W-1:0]      data;
    logic [LEN_W-1:0]       count;
  } secs_desc_t;

endpackage

`default_nettype wire

@@ hdl/secs_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one command word.
// Depends on secs_pkg for field widths.
`default_nettype none

interface secs_cmd_if;
  import secs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [IN_ADDR_W-1:0] address;
  logic [LEN_W-1:0]     length;
  logic [BYTE_W-1:0]    data_byte;

  modport source (output valid, output mode, output address, output length,
                  output data_byte, input ready);
  modport sink   (input valid, input mode, input address, input length,
                  input data_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/secs_act_if.sv @@
// Action channel: valid/ready handshake carrying one SPI action word.
// Depends on secs_pkg for field widths.
`default_nettype none

interface secs_act_if;
  import secs_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] spi_byte;
  logic [LEN_W-1:0]  receive_count;
  logic              last;

  modport source (output valid, output kind, output spi_byte, output receive_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input spi_byte, input receive_count,
                  input last, output ready);
endinterface

`default_nettype wire

@@ hdl/spi_eeprom_command_sequencer_core.sv @@
// A taken command passes through the queue, the back end's mask register and the
// output register before its first action word is offered. Action words go out one
// per cycle unless act_o.ready stalls them; a command yields 1 to 10 words. Commands
// are taken one per cycle while the 4-entry queue between front and back end has room.
// Reset (rst_ni, async low) empties the queue and output and restores config defaults.
`default_nettype none

module spi_eeprom_command_sequencer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  secs_cmd_if.sink                         cmd_i,
  secs_act_if.source                       act_o,
  input  logic                             cfg_we_i,
  input  logic [secs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [secs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import secs_pkg::*;

  logic       q_full, q_push, q_empty, q_pop;
  secs_desc_t q_desc, q_head;

  // Classify commands
  secs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (q_desc)
  );

  // Decouple front and back
  secs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Emit action words
  secs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (q_head),
    .pop_o   (q_pop),
    .act_o   (act_o)
  );

endmodule

`default_nettype wire

@@ hdl/secs_front.sv @@
// Front end: config registers, request checks, write-session state, and
// classification of each command word into a slot mask. Uses secs_pkg, secs_cmd_if.
`default_nettype none

module secs_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  secs_cmd_if.sink                             cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [secs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [secs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output secs_pkg::secs_desc_t                 q_desc_o
);
  import secs_pkg::*;

  localparam int unsigned WIDE_W = ADDR_BITS + 1;

  // Configuration
  logic [LOG_W-1:0] cap_log2_q, page_log2_q;
  logic [NB_W-1:0]  addr_bytes_q;
  logic             hbo_q;

  // Write session
  logic [ADDR_BITS-1:0] next_addr_q, next_addr_d;
  logic [LEN_W-1:0]     bytes_rem_q, bytes_rem_d;
  logic [LEN_W-1:0]     page_left_q, page_left_d;
  logic                 write_active_q, write_active_d;

  logic                 accept;
  logic [LOG_W-1:0]     cap_lg, pg_lg;
  logic [WIDE_W-1:0]    cap_size, in_addr_w, len_w, room_to_end;
  logic [WIDE_W-1:0]    pg_size, pg_off, pg_room, rem_w, na_w;
  logic [LEN_W-1:0]     clamped, page_start, page_cur, page_after, rem_after;
  logic                 req_ok, page_open, new_page;
  logic [NB_W-1:0]      nb_eff;
  secs_mask_t           pre_mask, hdr_mask;
  secs_desc_t           desc;

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q   <= CAP_LOG2_RST;
      page_log2_q  <= PAGE_LOG2_RST;
      addr_bytes_q <= ADDR_BYTES_RST;
      hbo_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (secs_cfg_e'(cfg_idx_i))
        CFG_CAPACITY_LOG2:      cap_log2_q   <= cfg_wdata_i;
        CFG_PAGE_LOG2:          page_log2_q  <= cfg_wdata_i;
        CFG_ADDRESS_BYTES:      addr_bytes_q <= cfg_wdata_i[NB_W-1:0];
        CFG_HIGH_BIT_IN_OPCODE: hbo_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Geometry and request check
  always_comb begin
    cap_lg      = (cap_log2_q > LOG_W'(ADDR_BITS)) ? LOG_W'(ADDR_BITS) : cap_log2_q;
    cap_size    = {{(WIDE_W-1){1'b0}}, 1'b1} << cap_lg;
    in_addr_w   = {{(WIDE_W-IN_ADDR_W){1'b0}}, cmd_i.address};
    len_w       = {{(WIDE_W-LEN_W){1'b0}}, cmd_i.length};
    room_to_end = cap_size - in_addr_w;
    clamped     = (len_w > room_to_end) ? room_to_end[LEN_W-1:0] : cmd_i.length;
    req_ok      = (in_addr_w < cap_size) && (cmd_i.length != '0);
  end

  // Page arithmetic for the next data byte
  always_comb begin
    pg_lg      = (page_log2_q < cap_lg) ? page_log2_q : cap_lg;
    pg_size    = {{(WIDE_W-1){1'b0}}, 1'b1} << pg_lg;
    na_w       = {1'b0, next_addr_q};
    pg_off     = na_w & (pg_size - 1'b1);
    pg_room    = pg_size - pg_off;
    rem_w      = {{(WIDE_W-LEN_W){1'b0}}, bytes_rem_q};
    new_page   = (page_left_q == '0);
    page_start = (pg_room < rem_w) ? pg_room[LEN_W-1:0] : bytes_rem_q;
    page_cur   = new_page ? page_start : page_left_q;
    page_after = page_cur - 1'b1;
    rem_after  = bytes_rem_q - 1'b1;
  end

  // Common mask fragments
  always_comb begin
    page_open = write_active_q && (page_left_q != '0);
    nb_eff    = (addr_bytes_q == '0) ? NB_W'(1) : addr_bytes_q;
    pre_mask  = '0;
    pre_mask[SLOT_PRE_RELEASE] = page_open;
    pre_mask[SLOT_PRE_POLL]    = page_open;
    hdr_mask  = '0;
    hdr_mask[SLOT_OPCODE]   = 1'b1;
    hdr_mask[SLOT_ADDR_LO]  = 1'b1;
    hdr_mask[SLOT_ADDR_MID] = (nb_eff >= NB_W'(2));
    hdr_mask[SLOT_ADDR_HI]  = (nb_eff == NB_W'(3));
  end

  // Command classification and session update
  always_comb begin
    desc           = '0;
    desc.data      = cmd_i.data_byte;
    next_addr_d    = next_addr_q;
    bytes_rem_d    = bytes_rem_q;
    page_left_d    = page_left_q;
    write_active_d = write_active_q;
    case (secs_mode_e'(cmd_i.mode))
      MODE_BEGIN_WRITE: begin
        if (!req_ok) begin
          desc.mask[SLOT_ERROR] = 1'b1;
        end else begin
          desc.mask = pre_mask;
          desc.mask[SLOT_READY_POLL] = 1'b1;
          next_addr_d    = {{(ADDR_BITS-IN_ADDR_W){1'b0}}, cmd_i.address};
          bytes_rem_d    = clamped;
          page_left_d    = '0;
          write_active_d = 1'b1;
        end
      end
      MODE_WRITE_DATA: begin
        if (!write_active_q || (bytes_rem_q == '0)) begin
          desc.mask[SLOT_ERROR] = 1'b1;
        end else begin
          if (new_page) begin
            desc.mask = hdr_mask;
            desc.mask[SLOT_WREN]         = 1'b1;
            desc.mask[SLOT_WREN_RELEASE] = 1'b1;
          end
          desc.opcode = (hbo_q && next_addr_q[A8_BIT]) ? OP_WRITE_A8 : OP_WRITE;
          desc.addr   = next_addr_q;
          desc.mask[SLOT_DATA] = 1'b1;
          page_left_d = page_after;
          bytes_rem_d = rem_after;
          next_addr_d = next_addr_q + 1'b1;
          if (page_after == '0) begin
            desc.mask[SLOT_END_RELEASE] = 1'b1;
            desc.mask[SLOT_END_POLL]    = 1'b1;
          end
          if (rem_after == '0) begin
            desc.mask[SLOT_DONE] = 1'b1;
            write_active_d = 1'b0;
            page_left_d    = '0;
          end
        end
      end
      MODE_BEGIN_READ: begin
        if (!req_ok) begin
          desc.mask[SLOT_ERROR] = 1'b1;
        end else begin
          desc.mask   = pre_mask | hdr_mask;
          desc.mask[SLOT_RECEIVE]     = 1'b1;
          desc.mask[SLOT_END_RELEASE] = 1'b1;
          desc.opcode = (hbo_q && cmd_i.address[A8_BIT]) ? OP_READ_A8 : OP_READ;
          desc.addr   = {{(ADDR_BITS-IN_ADDR_W){1'b0}}, cmd_i.address};
          desc.count  = clamped;
          write_active_d = 1'b0;
          page_left_d    = '0;
        end
      end
      MODE_WRITE_STATUS: begin
        desc.mask = pre_mask;
        desc.mask[SLOT_READY_POLL]   = 1'b1;
        desc.mask[SLOT_WREN]         = 1'b1;
        desc.mask[SLOT_WREN_RELEASE] = 1'b1;
        desc.mask[SLOT_OPCODE]       = 1'b1;
        desc.mask[SLOT_DATA]         = 1'b1;
        desc.mask[SLOT_END_RELEASE]  = 1'b1;
        desc.opcode    = OP_WRSR;
        write_active_d = 1'b0;
        page_left_d    = '0;
      end
      MODE_READ_STATUS: begin
        desc.mask = pre_mask;
        desc.mask[SLOT_OPCODE]      = 1'b1;
        desc.mask[SLOT_RECEIVE]     = 1'b1;
        desc.mask[SLOT_END_RELEASE] = 1'b1;
        desc.opcode    = OP_RDSR;
        desc.count     = LEN_W'(1);
        write_active_d = 1'b0;
        page_left_d    = '0;
      end
      default: begin
        desc.mask[SLOT_ERROR] = 1'b1;
      end
    endcase
  end

  // Handshake: take a word whenever the queue has room
  assign cmd_i.ready = !q_full_i;
  assign accept      = cmd_i.valid && !q_full_i;
  assign q_push_o    = accept;
  assign q_desc_o    = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_addr_q    <= '0;
      bytes_rem_q    <= '0;
      page_left_q    <= '0;
      write_active_q <= 1'b0;
    end else if (accept) begin
      next_addr_q    <= next_addr_d;
      bytes_rem_q    <= bytes_rem_d;
      page_left_q    <= page_left_d;
      write_active_q <= write_active_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/secs_queue.sv @@
// Short FIFO of classified commands between front and back end.
// Uses secs_pkg for the descriptor type and depth.
`default_nettype none

module secs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  secs_pkg::secs_desc_t  desc_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output secs_pkg::secs_desc_t  head_o
);
  import secs_pkg::*;

  secs_desc_t            entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]     count_q;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= desc_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/secs_back.sv @@
// Back end: walks the current command's slot mask into an output register,
// one action word per cycle unless stalled; uses secs_pkg and secs_act_if.
`default_nettype none

module secs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  secs_pkg::secs_desc_t  head_i,
  output logic                  pop_o,
  secs_act_if.source            act_o
);
  import secs_pkg::*;

  // Lowest enabled slot goes out first
  function automatic secs_slot_e first_slot(input secs_mask_t m);
    secs_slot_e s;
    s = SLOT_ERROR;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        s = secs_slot_e'(4'(i));
      end
    end
    return s;
  endfunction

  secs_mask_t        act_mask_q, mask_left;
  secs_desc_t        act_q;
  secs_slot_e        cur;
  logic              last_slot, emit, act_done, out_free;

  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [LEN_W-1:0]  out_count_q;
  logic              out_last_q;

  secs_kind_e        kind;
  logic [BYTE_W-1:0] sbyte;
  logic [LEN_W-1:0]  rcount;

  // Slot selection and sequencing
  always_comb begin
    cur       = first_slot(act_mask_q);
    last_slot = ((act_mask_q & (act_mask_q - 1'b1)) == '0);
    mask_left = act_mask_q;
    mask_left[cur] = 1'b0;
    out_free  = !out_valid_q || act_o.ready;
    emit      = (act_mask_q != '0) && out_free;
    act_done  = emit && last_slot;
    pop_o     = !empty_i && ((act_mask_q == '0) || act_done);
  end

  // Action word for the current slot
  always_comb begin
    kind   = KIND_SEND;
    sbyte  = '0;
    rcount = '0;
    case (cur)
      SLOT_PRE_RELEASE:  kind = KIND_RELEASE;
      SLOT_PRE_POLL:     kind = KIND_POLL;
      SLOT_READY_POLL:   kind = KIND_POLL;
      SLOT_WREN:         sbyte = OP_WREN;
      SLOT_WREN_RELEASE: kind = KIND_RELEASE;
      SLOT_OPCODE:       sbyte = act_q.opcode;
      SLOT_ADDR_HI:      sbyte = act_q.addr[23:16];
      SLOT_ADDR_MID:     sbyte = act_q.addr[15:8];
      SLOT_ADDR_LO:      sbyte = act_q.addr[7:0];
      SLOT_DATA:         sbyte = act_q.data;
      SLOT_RECEIVE: begin
        kind   = KIND_RECEIVE;
        rcount = act_q.count;
      end
      SLOT_END_RELEASE:  kind = KIND_RELEASE;
      SLOT_END_POLL:     kind = KIND_POLL;
      SLOT_DONE:         kind = KIND_DONE;
      SLOT_ERROR:        kind = KIND_ERROR;
      default:           kind = KIND_ERROR;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mask_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        act_mask_q <= head_i.mask;
      end else if (emit) begin
        act_mask_q <= mask_left;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (act_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      act_q <= head_i;
    end
    if (emit) begin
      out_kind_q  <= kind;
      out_byte_q  <= sbyte;
      out_count_q <= rcount;
      out_last_q  <= last_slot;
    end
  end

  assign act_o.valid         = out_valid_q;
  assign act_o.kind          = out_kind_q;
  assign act_o.spi_byte      = out_byte_q;
  assign act_o.receive_count = out_count_q;
  assign act_o.last          = out_last_q;

endmodule

`default_nettype wire

@@ hdl/secs_checker.sv @@
// Port-level checks on the action channel of the sequencer core.
// Uses secs_pkg, secs_act_if and assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"

module secs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  secs_act_if.source  act_o
);
  import secs_pkg::*;

  // A stalled word stays offered
  `SECS_ASSERT_NXT(a_valid_hold, act_o.valid && !act_o.ready, act_o.valid, "action word dropped while stalled")

  // Words of one command stream without gaps
  `SECS_ASSERT_NXT(a_no_bubble, act_o.valid && act_o.ready && !act_o.last, act_o.valid, "gap inside a command's action words")

  // Error and done always close a command
  `SECS_ASSERT_IMP(a_end_last, act_o.valid && (act_o.kind == KIND_ERROR || act_o.kind == KIND_DONE), act_o.last, "error or done word not marked last")

  // A receive burst is never empty
  `SECS_ASSERT_IMP(a_recv_nonzero, act_o.valid && act_o.kind == KIND_RECEIVE, act_o.receive_count != '0, "receive word with zero count")

endmodule

bind spi_eeprom_command_sequencer_core secs_checker u_secs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .act_o  (act_o)
);

`default_nettype wire

@@ tb/tb_spi_eeprom_command_sequencer_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for spi_eeprom_command_sequencer_core: directed and random
// command words, a cycle-free model of the expected action words, field-by-field checks.
// Depends on secs_pkg, secs_cmd_if, secs_act_if and the core.

module tb_spi_eeprom_command_sequencer_core;
  import secs_pkg::*;

  localparam int unsigned IDLE_PCT     = 19;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AT_A    = 200;
  localparam int unsigned HOLD_AT_B    = 900;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned ADDR_MASK    = (1 << ADDR_BITS) - 1;
  localparam int unsigned IN_SPAN      = 1 << IN_ADDR_W;
  localparam logic [MODE_W-1:0] MODE_TOP = '1;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [IN_ADDR_W-1:0] address;
    logic [LEN_W-1:0]     length;
    logic [BYTE_W-1:0]    data_byte;
  } command_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] spi_byte;
    logic [LEN_W-1:0]  receive_count;
    logic              last;
  } action_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  secs_cmd_if cmd ();
  secs_act_if act ();

  spi_eeprom_command_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .act_o       (act),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the device geometry registers
  logic [LOG_W-1:0] cap_log2_q   = CAP_LOG2_RST;
  logic [LOG_W-1:0] page_log2_q  = PAGE_LOG2_RST;
  logic [NB_W-1:0]  addr_bytes_q = ADDR_BYTES_RST;
  logic             hi_bit_q     = 1'b0;

  // Shadow of the write sequencing state
  int unsigned wr_addr      = 0;
  int unsigned wr_remaining = 0;
  int unsigned page_left    = 0;
  bit          wr_open      = 1'b0;

  command_t pending_cmds[$];
  action_t  expected_actions[$];
  action_t  frame_words[$];

  int unsigned err_count    = 0;
  int unsigned words_seen   = 0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;
  int unsigned queued_items = 0;
  bit          steady       = 1'b0;
  action_t     want;
  command_t    taken;

  // ---------------------------------------------------------------- geometry
  function automatic int unsigned eff_cap_log();
    return (cap_log2_q > ADDR_BITS) ? ADDR_BITS : cap_log2_q;
  endfunction

  function automatic int unsigned page_span();
    int unsigned pl;
    pl = (page_log2_q < eff_cap_log()) ? page_log2_q : eff_cap_log();
    return 1 << pl;
  endfunction

  // Clamped byte count of a request, 0 when the request is rejected
  function automatic int unsigned clamp_len(int unsigned addr, int unsigned len);
    int unsigned cap;
    cap = 1 << eff_cap_log();
    if (len == 0 || addr >= cap) return 0;
    return (len > cap - addr) ? cap - addr : len;
  endfunction

  // ---------------------------------------------------------------- action prediction
  task automatic add_word(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] n);
    action_t w;
    w.kind          = k;
    w.spi_byte      = b;
    w.receive_count = n;
    w.last          = 1'b0;
    frame_words.push_back(w);
  endtask

  // Abandon an open page: release and poll, then drop the write
  task automatic close_open_page();
    if (wr_open && page_left != 0) begin
      add_word(KIND_RELEASE, '0, '0);
      add_word(KIND_POLL, '0, '0);
    end
    wr_open   = 1'b0;
    page_left = 0;
  endtask

  // Opcode, with address bit 8 folded in when enabled, then the address bytes MSB first
  task automatic send_header(logic [BYTE_W-1:0] op, logic [BYTE_W-1:0] op_a8,
                             int unsigned addr);
    int unsigned nb;
    nb = (addr_bytes_q == 0) ? 1 : addr_bytes_q;
    if (hi_bit_q && ((addr >> A8_BIT) & 1) != 0) add_word(KIND_SEND, op_a8, '0);
    else add_word(KIND_SEND, op, '0);
    for (int unsigned i = 0; i < nb; i++)
      add_word(KIND_SEND, BYTE_W'(addr >> (8 * (nb - 1 - i))), '0);
  endtask

  task automatic predict_actions(command_t c);
    int unsigned clamped, psize, room;
    case (c.mode)
      MODE_BEGIN_WRITE: begin
        clamped = clamp_len(c.address, c.length);
        if (clamped == 0) begin
          add_word(KIND_ERROR, '0, '0);
        end else begin
          close_open_page();
          add_word(KIND_POLL, '0, '0);
          wr_addr      = c.address;
          wr_remaining = clamped;
          page_left    = 0;
          wr_open      = 1'b1;
        end
      end
      MODE_WRITE_DATA: begin
        if (!wr_open || wr_remaining == 0) begin
          add_word(KIND_ERROR, '0, '0);
        end else begin
          // first byte of a page opens the frame
          if (page_left == 0) begin
            psize     = page_span();
            room      = psize - (wr_addr & (psize - 1));
            page_left = (room < wr_remaining) ? room : wr_remaining;
            add_word(KIND_SEND, OP_WREN, '0);
            add_word(KIND_RELEASE, '0, '0);
            send_header(OP_WRITE, OP_WRITE_A8, wr_addr);
          end
          add_word(KIND_SEND, c.data_byte, '0);
          page_left--;
          wr_remaining--;
          wr_addr = (wr_addr + 1) & ADDR_MASK;
          if (page_left == 0) begin
            add_word(KIND_RELEASE, '0, '0);
            add_word(KIND_POLL, '0, '0);
          end
          if (wr_remaining == 0) begin
            add_word(KIND_DONE, '0, '0);
            wr_open   = 1'b0;
            page_left = 0;
          end
        end
      end
      MODE_BEGIN_READ: begin
        clamped = clamp_len(c.address, c.length);
        if (clamped == 0) begin
          add_word(KIND_ERROR, '0, '0);
        end else begin
          close_open_page();
          send_header(OP_READ, OP_READ_A8, c.address);
          add_word(KIND_RECEIVE, '0, LEN_W'(clamped));
          add_word(KIND_RELEASE, '0, '0);
        end
      end
      MODE_WRITE_STATUS: begin
        close_open_page();
        add_word(KIND_POLL, '0, '0);
        add_word(KIND_SEND, OP_WREN, '0);
        add_word(KIND_RELEASE, '0, '0);
        add_word(KIND_SEND, OP_WRSR, '0);
        add_word(KIND_SEND, c.data_byte, '0);
        add_word(KIND_RELEASE, '0, '0);
      end
      MODE_READ_STATUS: begin
        close_open_page();
        add_word(KIND_SEND, OP_RDSR, '0);
        add_word(KIND_RECEIVE, '0, LEN_W'(1));
        add_word(KIND_RELEASE, '0, '0);
      end
      default: add_word(KIND_ERROR, '0, '0);
    endcase
    // move the frame to the expectation store, flagging its final word
    for (int i = 0; i < frame_words.size(); i++) begin
      want      = frame_words[i];
      want.last = (i == frame_words.size() - 1);
      expected_actions.push_back(want);
    end
    frame_words.delete();
  endtask

  // ---------------------------------------------------------------- mismatch report
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch at word %0d: %s got %0h, expected %0h", words_seen, what, got,
             exp_val);
    err_count++;
  endtask

  // ---------------------------------------------------------------- command driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd.valid && cmd.ready) begin
        taken = pending_cmds.pop_front();
        predict_actions(taken);
      end
      if (cmd.valid && !cmd.ready) begin
        // hold the offered word
      end else if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        cmd.valid     <= 1'b1;
        cmd.mode      <= pending_cmds[0].mode;
        cmd.address   <= pending_cmds[0].address;
        cmd.length    <= pending_cmds[0].length;
        cmd.data_byte <= pending_cmds[0].data_byte;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- action monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (act.valid && act.ready) begin
        if (expected_actions.size() == 0) begin
          report_mismatch("unexpected word, kind", act.kind, '0);
        end else begin
          want = expected_actions.pop_front();
          if (act.kind !== want.kind) report_mismatch("kind", act.kind, want.kind);
          if (act.spi_byte !== want.spi_byte)
            report_mismatch("spi_byte", act.spi_byte, want.spi_byte);
          if (act.receive_count !== want.receive_count)
            report_mismatch("receive_count", act.receive_count, want.receive_count);
          if (act.last !== want.last) report_mismatch("last", act.last, want.last);
        end
        words_seen++;
        // long back-pressure so the command queue fills and stalls the input
        if (words_seen == HOLD_AT_A || words_seen == HOLD_AT_B) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        act.ready <= 1'b0;
      end else if (steady) begin
        act.ready <= 1'b1;
      end else begin
        act.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  task automatic queue_cmd(logic [MODE_W-1:0] m, logic [IN_ADDR_W-1:0] a,
                           logic [LEN_W-1:0] n, logic [BYTE_W-1:0] d);
    command_t c;
    c.mode      = m;
    c.address   = a;
    c.length    = n;
    c.data_byte = d;
    pending_cmds.push_back(c);
    queued_items++;
  endtask

  function automatic logic [IN_ADDR_W-1:0] rand_addr();
    return IN_ADDR_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    return LEN_W'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom);
  endfunction

  function automatic int unsigned addr_span();
    int unsigned cap;
    cap = 1 << eff_cap_log();
    return (cap > IN_SPAN) ? IN_SPAN : cap;
  endfunction

  // Begin write plus its data words, sometimes cut short or overrun
  task automatic queue_write_burst();
    int unsigned span, psize, a, len, n, pick;
    span  = addr_span();
    psize = page_span();
    pick  = $urandom_range(99);
    if (pick < 45) a = ((($urandom % span) & ~(psize - 1)) + psize - $urandom_range(3, 0)) % span;
    else if (pick < 55) a = span - $urandom_range(8, 1);
    else a = $urandom % span;
    len = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range((1 << LEN_W) - 1, 1);
    n = clamp_len(a, len);
    if (n > 40) n = 40;
    if ($urandom_range(99) < 15) n = $urandom_range(n, 0);
    queue_cmd(MODE_BEGIN_WRITE, IN_ADDR_W'(a), LEN_W'(len), rand_byte());
    repeat (n) queue_cmd(MODE_WRITE_DATA, rand_addr(), rand_len(), rand_byte());
    if ($urandom_range(99) < 8) queue_cmd(MODE_WRITE_DATA, rand_addr(), rand_len(), rand_byte());
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned stop, pick;
    logic [MODE_W-1:0] m;
    stop = queued_items + count;
    while (queued_items < stop) begin
      pick = $urandom_range(99);
      m    = $urandom_range(1) ? MODE_BEGIN_WRITE : MODE_BEGIN_READ;
      if (pick < 55) begin
        queue_write_burst();
      end else if (pick < 70) begin
        queue_cmd(MODE_BEGIN_READ,
                  (pick < 64) ? IN_ADDR_W'($urandom % addr_span()) : rand_addr(),
                  $urandom_range(1) ? rand_len() : LEN_W'($urandom_range(16, 1)), rand_byte());
      end else if (pick < 78) begin
        queue_cmd(MODE_WRITE_STATUS, rand_addr(), rand_len(), rand_byte());
      end else if (pick < 85) begin
        queue_cmd(MODE_READ_STATUS, rand_addr(), rand_len(), rand_byte());
      end else begin
        // noise and broken sequences
        case ($urandom_range(4))
          0: queue_cmd(MODE_WRITE_DATA, rand_addr(), rand_len(), rand_byte());
          1: queue_cmd($urandom_range(MODE_TOP, MODE_READ_STATUS + 1), rand_addr(), rand_len(),
                       rand_byte());
          2: queue_cmd(m, rand_addr(), '0, rand_byte());
          3: queue_cmd(m, rand_addr(), rand_len(), rand_byte());
          default: begin
            queue_cmd(MODE_BEGIN_WRITE, IN_ADDR_W'($urandom % addr_span()),
                      LEN_W'($urandom_range(24, 2)), rand_byte());
            queue_cmd(MODE_WRITE_DATA, rand_addr(), rand_len(), rand_byte());
            queue_cmd(MODE_READ_STATUS, rand_addr(), rand_len(), rand_byte());
          end
        endcase
      end
    end
  endtask

  // Wait until every command is taken and every action word has come back
  task automatic settle();
    while (pending_cmds.size() != 0 || expected_actions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(secs_cfg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CAPACITY_LOG2:      cap_log2_q   = val;
      CFG_PAGE_LOG2:          page_log2_q  = val;
      CFG_ADDRESS_BYTES:      addr_bytes_q = val[NB_W-1:0];
      CFG_HIGH_BIT_IN_OPCODE: hi_bit_q     = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_geometry(logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] page,
                                logic [CFG_DATA_W-1:0] nb, logic [CFG_DATA_W-1:0] hi);
    write_reg(CFG_CAPACITY_LOG2, cap);
    write_reg(CFG_PAGE_LOG2, page);
    write_reg(CFG_ADDRESS_BYTES, nb);
    write_reg(CFG_HIGH_BIT_IN_OPCODE, hi);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    cmd.valid     = 1'b0;
    cmd.mode      = '0;
    cmd.address   = '0;
    cmd.length    = '0;
    cmd.data_byte = '0;
    act.ready     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words on the reset geometry: 8 KiB, 32 B pages, two address bytes
    queue_cmd(MODE_WRITE_DATA, '1, '1, 8'hFF);          // data with no write open
    queue_cmd(MODE_TOP, '1, '1, 8'hFF);                 // unused mode
    queue_cmd(MODE_READ_STATUS + 1, '0, '0, '0);        // unused mode
    queue_cmd(MODE_BEGIN_WRITE, '0, '0, '0);            // zero length
    queue_cmd(MODE_BEGIN_WRITE, 19'd8192, 20'd5, '0);   // address at capacity
    queue_cmd(MODE_BEGIN_READ, '1, '1, '0);             // address beyond capacity
    queue_cmd(MODE_BEGIN_READ, '0, '1, '1);             // clamped to whole memory
    queue_cmd(MODE_BEGIN_READ, '0, '0, '0);             // zero length read
    queue_cmd(MODE_READ_STATUS, '0, '0, '0);
    queue_cmd(MODE_WRITE_STATUS, '1, '1, 8'hFF);
    // clamped at end of memory
    queue_cmd(MODE_BEGIN_WRITE, 19'd8190, 20'd100, '0);
    queue_cmd(MODE_WRITE_DATA, '0, '0, 8'h00);
    queue_cmd(MODE_WRITE_DATA, '0, '0, 8'hFF);
    // crosses a page boundary
    queue_cmd(MODE_BEGIN_WRITE, 19'd30, 20'd4, '0);
    repeat (4) queue_cmd(MODE_WRITE_DATA, rand_addr(), rand_len(), rand_byte());
    // read abandons an open page
    queue_cmd(MODE_BEGIN_WRITE, 19'd5, 20'd10, '0);
    queue_cmd(MODE_WRITE_DATA, '0, '0, 8'h5A);
    queue_cmd(MODE_BEGIN_READ, 19'd100, 20'd3, '0);
    // status read while armed but no page open, then the write is gone
    queue_cmd(MODE_BEGIN_WRITE, '0, 20'd1, '0);
    queue_cmd(MODE_READ_STATUS, '0, '0, '0);
    queue_cmd(MODE_WRITE_DATA, '0, '0, 8'hA5);
    queue_random(75);

    // smallest memory and page, one address byte
    settle();
    apply_geometry(5'd7, 5'd3, 5'd1, 5'd0);
    queue_random(80);

    // capacity above the address space, address byte count zero, opcode high bit
    settle();
    apply_geometry(5'd31, 5'd8, 5'b00100, 5'd1);
    queue_random(80);

    // memory spanning the full input address range, no page limit, three address bytes, no idling on either side
    settle();
    steady = 1'b1;
    apply_geometry(5'd19, 5'd19, 5'd3, 5'd1);
    queue_random(80);

    // 512 B memory so address bit 8 lands in the opcode; page above capacity
    settle();
    steady = 1'b0;
    apply_geometry(5'd9, 5'd31, 5'd2, 5'b11111);
    queue_random(80);

    settle();
    apply_geometry(5'd16, 5'd6, 5'b11111, 5'b11110);
    queue_random(100);

    settle();
    repeat (12) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
